/* hw/rtl/ohq_pkg.sv */
// shared types, codes and constants of the occupancy qualifier
package ohq_pkg;

	localparam int SPOTS_DEF = 16;
	localparam int SPOT_W    = 4;
	localparam int DIST_W    = 16;
	localparam int STATE_W   = 2;
	localparam int CNT_W     = 4;
	localparam int HEALTH_W  = 2;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [STATE_W-1:0] ST_UNKNOWN  = 2'd0;
	localparam logic [STATE_W-1:0] ST_FREE     = 2'd1;
	localparam logic [STATE_W-1:0] ST_OCCUPIED = 2'd2;

	localparam logic [HEALTH_W-1:0] HE_NONE    = 2'd0;
	localparam logic [HEALTH_W-1:0] HE_FAULT   = 2'd1;
	localparam logic [HEALTH_W-1:0] HE_RECOVER = 2'd2;

	localparam logic [1:0] REG_OCC_THR  = 2'd0;
	localparam logic [1:0] REG_FREE_THR = 2'd1;
	localparam logic [1:0] REG_CONFIRM  = 2'd2;
	localparam logic [1:0] REG_TIMEOUT  = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

	localparam logic [DIST_W-1:0] OCC_THR_RST  = 16'd8000;
	localparam logic [DIST_W-1:0] FREE_THR_RST = 16'd10000;
	localparam logic [CNT_W-1:0]  CONFIRM_RST  = 4'd3;
	localparam logic [CNT_W-1:0]  TIMEOUT_RST  = 4'd3;

	typedef struct packed {
		logic [DIST_W-1:0] occ_thr;
		logic [DIST_W-1:0] free_thr;
		logic [CNT_W-1:0]  confirm;
		logic [CNT_W-1:0]  tmo_limit;
	} cfg_t;

	typedef struct packed {
		logic [STATE_W-1:0] qual;
		logic [STATE_W-1:0] prop;
		logic [CNT_W-1:0]   prop_cnt;
		logic [CNT_W-1:0]   miss;
		logic               fault;
		logic [STATE_W-1:0] rep;
	} ent_t;

	typedef struct packed {
		logic                changed;
		logic [HEALTH_W-1:0] health;
	} upd_res_t;

	localparam int ENT_W = $bits(ent_t);

endpackage

/* hw/rtl/ohq_ram.sv */
// generic single write port ram with registered read
module ohq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/ohq_cfg.sv */
// configuration register file behind the apb port
module ohq_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ohq_pkg::PADDR_W-1:0]  paddr,
	input  logic [ohq_pkg::PDATA_W-1:0]  pwdata,
	output logic [ohq_pkg::PDATA_W-1:0]  prdata,
	output ohq_pkg::cfg_t                cfg
);

	ohq_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.occ_thr   <= ohq_pkg::OCC_THR_RST;
			cfg_q.free_thr  <= ohq_pkg::FREE_THR_RST;
			cfg_q.confirm   <= ohq_pkg::CONFIRM_RST;
			cfg_q.tmo_limit <= ohq_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				ohq_pkg::REG_OCC_THR:  cfg_q.occ_thr   <= pwdata[15:0];
				ohq_pkg::REG_FREE_THR: cfg_q.free_thr  <= pwdata[15:0];
				ohq_pkg::REG_CONFIRM:  cfg_q.confirm   <= pwdata[3:0];
				ohq_pkg::REG_TIMEOUT:  cfg_q.tmo_limit <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ohq_pkg::REG_OCC_THR:  prdata = {16'd0, cfg_q.occ_thr};
			ohq_pkg::REG_FREE_THR: prdata = {16'd0, cfg_q.free_thr};
			ohq_pkg::REG_CONFIRM:  prdata = {28'd0, cfg_q.confirm};
			ohq_pkg::REG_TIMEOUT:  prdata = {28'd0, cfg_q.tmo_limit};
			default:               prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/ohq_upd.sv */
// per-channel next-state logic: miss counting, fault flag, hysteresis and debounce
module ohq_upd (
	input  ohq_pkg::cfg_t                cfg,
	input  ohq_pkg::ent_t                cur,
	input  logic                         timed_out,
	input  logic [ohq_pkg::DIST_W-1:0]   distance,
	output ohq_pkg::ent_t                nxt,
	output ohq_pkg::upd_res_t            res
);

	logic [ohq_pkg::STATE_W-1:0] prop;
	logic                        below_occ;
	logic                        above_free;

	assign below_occ  = distance < cfg.occ_thr;
	assign above_free = distance > cfg.free_thr;

	always_comb begin
		nxt  = cur;
		res  = '0;
		prop = cur.qual;
		if (timed_out) begin
			if (cur.miss != ohq_pkg::CNT_MAX) begin
				nxt.miss = cur.miss + 4'd1;
			end
			if ((nxt.miss >= cfg.tmo_limit) && !cur.fault) begin
				nxt.fault  = 1'b1;
				res.health = ohq_pkg::HE_FAULT;
			end
		end else begin
			nxt.miss = '0;
			if (cur.fault) begin
				nxt.fault  = 1'b0;
				res.health = ohq_pkg::HE_RECOVER;
			end
			case (cur.qual)
				ohq_pkg::ST_UNKNOWN: begin
					prop = below_occ ? ohq_pkg::ST_OCCUPIED : ohq_pkg::ST_FREE;
				end
				ohq_pkg::ST_FREE: begin
					if (below_occ) prop = ohq_pkg::ST_OCCUPIED;
				end
				ohq_pkg::ST_OCCUPIED: begin
					if (above_free) prop = ohq_pkg::ST_FREE;
				end
				default: prop = cur.qual;
			endcase
			if (prop == cur.qual) begin
				nxt.prop     = ohq_pkg::ST_UNKNOWN;
				nxt.prop_cnt = '0;
			end else begin
				if (cur.prop == prop) begin
					if (cur.prop_cnt != ohq_pkg::CNT_MAX) begin
						nxt.prop_cnt = cur.prop_cnt + 4'd1;
					end
				end else begin
					nxt.prop     = prop;
					nxt.prop_cnt = 4'd1;
				end
				if (nxt.prop_cnt >= cfg.confirm) begin
					nxt.qual     = prop;
					nxt.prop     = ohq_pkg::ST_UNKNOWN;
					nxt.prop_cnt = '0;
				end
			end
			if ((nxt.qual != ohq_pkg::ST_UNKNOWN) && (nxt.qual != cur.rep)) begin
				res.changed = 1'b1;
				nxt.rep     = nxt.qual;
			end
		end
	end

endmodule

/* hw/rtl/occupancy_hysteresis_qualifier_core.sv */
// top level of the occupancy qualifier: state ram pipeline, forwarding and output register
// a beat reads the ram at accept, then writes back as the output register loads
// throughput: one beat per cycle while the output register is not stalled by out_ready
// the channel state ram is read at accept and written when stage 1 advances; a one-entry
// bypass covers back-to-back beats on the same channel
// reset: config registers take their defaults and per-channel valid bits clear at once,
// so every channel reads as cleared state; no clearing pass
module occupancy_hysteresis_qualifier_core #(
	parameter int SPOTS = ohq_pkg::SPOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ohq_pkg::PADDR_W-1:0]    paddr,
	input  logic [ohq_pkg::PDATA_W-1:0]    pwdata,
	output logic [ohq_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ohq_pkg::SPOT_W-1:0]     spot,
	input  logic                           timed_out,
	input  logic [ohq_pkg::DIST_W-1:0]     distance,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ohq_pkg::SPOT_W-1:0]     spot_out,
	output logic [ohq_pkg::STATE_W-1:0]    spot_state,
	output logic                           state_changed,
	output logic [ohq_pkg::HEALTH_W-1:0]   health_event,
	output logic                           faulty,
	output logic [ohq_pkg::DIST_W-1:0]     distance_out
);

	localparam int AW = (SPOTS > 1) ? $clog2(SPOTS) : 1;

	ohq_pkg::cfg_t     cfg;
	ohq_pkg::ent_t     rd_ent;
	ohq_pkg::ent_t     cur_ent;
	ohq_pkg::ent_t     nxt_ent;
	ohq_pkg::upd_res_t upd_res;

	logic                          acc;
	logic                          drop_in;
	logic [AW-1:0]                 addr_in;
	logic                          out_free;
	logic                          adv_s1;
	logic                          wr;

	logic                          v_s1;
	logic                          drop_s1;
	logic                          ev_s1;
	logic [AW-1:0]                 addr_s1;
	logic [ohq_pkg::SPOT_W-1:0]    spot_s1;
	logic                          to_s1;
	logic [ohq_pkg::DIST_W-1:0]    dist_s1;

	logic [SPOTS-1:0]              vld_q;
	logic                          fwd_v_q;
	logic [AW-1:0]                 fwd_addr_q;
	ohq_pkg::ent_t                 fwd_ent_q;

	logic                          out_valid_q;
	logic [ohq_pkg::SPOT_W-1:0]    spot_out_q;
	logic [ohq_pkg::STATE_W-1:0]   state_out_q;
	logic                          changed_out_q;
	logic [ohq_pkg::HEALTH_W-1:0]  health_out_q;
	logic                          faulty_out_q;
	logic [ohq_pkg::DIST_W-1:0]    dist_out_q;

	assign pready = 1'b1;

	ohq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign drop_in  = 32'(spot) >= SPOTS;
	assign addr_in  = AW'(spot);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || out_free;
	assign acc      = in_valid && in_ready;
	assign adv_s1   = v_s1 && out_free;
	assign wr       = adv_s1 && !drop_s1;

	ohq_ram #(
		.WIDTH (ohq_pkg::ENT_W),
		.DEPTH (SPOTS)
	) u_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (addr_s1),
		.wdata (nxt_ent),
		.re    (acc),
		.raddr (addr_in),
		.rdata (rd_ent)
	);

	always_comb begin
		if (fwd_v_q && (fwd_addr_q == addr_s1)) begin
			cur_ent = fwd_ent_q;
		end else if (ev_s1) begin
			cur_ent = rd_ent;
		end else begin
			cur_ent = '0;
		end
	end

	ohq_upd u_upd (
		.cfg       (cfg),
		.cur       (cur_ent),
		.timed_out (to_s1),
		.distance  (dist_s1),
		.nxt       (nxt_ent),
		.res       (upd_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			vld_q       <= '0;
			fwd_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (wr) begin
				vld_q[addr_s1] <= 1'b1;
				fwd_v_q        <= 1'b1;
			end
			if (out_free) begin
				out_valid_q <= wr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			drop_s1 <= drop_in;
			ev_s1   <= !drop_in && vld_q[addr_in];
			addr_s1 <= addr_in;
			spot_s1 <= spot;
			to_s1   <= timed_out;
			dist_s1 <= distance;
		end
		if (wr) begin
			fwd_addr_q    <= addr_s1;
			fwd_ent_q     <= nxt_ent;
			spot_out_q    <= spot_s1;
			state_out_q   <= nxt_ent.qual;
			changed_out_q <= upd_res.changed;
			health_out_q  <= upd_res.health;
			faulty_out_q  <= nxt_ent.fault;
			dist_out_q    <= to_s1 ? '0 : dist_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign spot_out      = spot_out_q;
	assign spot_state    = state_out_q;
	assign state_changed = changed_out_q;
	assign health_event  = health_out_q;
	assign faulty        = faulty_out_q;
	assign distance_out  = dist_out_q;

`ifndef SYNTHESIS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && out_valid_q && !out_ready))
		else $error("input stalled while the output slot is free");

	a_change_known: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && state_changed) |-> (spot_state != ohq_pkg::ST_UNKNOWN))
		else $error("change reported for an unknown state");

	a_fault_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (health_event == ohq_pkg::HE_FAULT)) |-> (faulty && (distance_out == '0)))
		else $error("fault event without fault flag on a timeout beat");

	a_recover_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (health_event == ohq_pkg::HE_RECOVER)) |-> !faulty)
		else $error("recovery event with fault flag still set");

	a_write_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> (fwd_v_q && out_valid_q))
		else $error("write-back did not load bypass and output register");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the occupancy qualifier core, with its own channel-state predictor
module testbench;
	import ohq_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_N       = 22;
	localparam int PHASE_N     = 6;
	localparam int PHASE_BEATS = 110;

	typedef struct packed {
		logic [SPOT_W-1:0]   spot;
		logic [STATE_W-1:0]  state;
		logic                changed;
		logic [HEALTH_W-1:0] health;
		logic                faulty;
		logic [DIST_W-1:0]   dval;
	} spot_report_t;

	typedef struct packed {
		logic [SPOT_W-1:0]   spot;
		logic                to;
		logic [DIST_W-1:0]   dval;
		logic                typed;
		logic [STATE_W-1:0]  e_state;
		logic                e_changed;
		logic [HEALTH_W-1:0] e_health;
		logic                e_faulty;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [SPOT_W-1:0]   spot;
	logic                timed_out;
	logic [DIST_W-1:0]   distance;
	logic                out_valid;
	logic                out_ready;
	logic [SPOT_W-1:0]   spot_out;
	logic [STATE_W-1:0]  spot_state;
	logic                state_changed;
	logic [HEALTH_W-1:0] health_event;
	logic                faulty;
	logic [DIST_W-1:0]   distance_out;

	occupancy_hysteresis_qualifier_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.spot(spot), .timed_out(timed_out), .distance(distance),
		.out_valid(out_valid), .out_ready(out_ready),
		.spot_out(spot_out), .spot_state(spot_state), .state_changed(state_changed),
		.health_event(health_event), .faulty(faulty), .distance_out(distance_out)
	);

	// predictor copy of configuration and per-channel state
	cfg_t               cfg;
	logic [STATE_W-1:0] qual_st [SPOTS_DEF];
	logic [STATE_W-1:0] prop_st [SPOTS_DEF];
	logic [CNT_W-1:0]   prop_cnt [SPOTS_DEF];
	logic [CNT_W-1:0]   miss_cnt [SPOTS_DEF];
	logic               fault_st [SPOTS_DEF];
	logic [STATE_W-1:0] rep_st [SPOTS_DEF];

	spot_report_t pending_reports[$];
	dir_row_t     dir_tab [DIR_N];
	int           errors;
	int           results_seen;
	int           cycle_cnt;
	int           beats_sent;
	int           burst_left;
	bit           hold_ask;

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch: %s got %0d want %0d (result %0d)", what, got, want, results_seen);
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	function automatic spot_report_t predict_report(input logic [SPOT_W-1:0] ch,
			input logic to, input logic [DIST_W-1:0] dval);
		spot_report_t       r;
		logic [STATE_W-1:0] cur;
		logic [STATE_W-1:0] nxt;
		r = '0;
		r.spot = ch;
		r.health = HE_NONE;
		if (to) begin
			if (miss_cnt[ch] != CNT_MAX)
				miss_cnt[ch]++;
			if (miss_cnt[ch] >= cfg.tmo_limit && !fault_st[ch]) begin
				fault_st[ch] = 1'b1;
				r.health = HE_FAULT;
			end
		end else begin
			miss_cnt[ch] = '0;
			if (fault_st[ch]) begin
				fault_st[ch] = 1'b0;
				r.health = HE_RECOVER;
			end
			cur = qual_st[ch];
			nxt = cur;
			if (cur == ST_UNKNOWN)
				nxt = (dval < cfg.occ_thr) ? ST_OCCUPIED : ST_FREE;
			else if (cur == ST_FREE && dval < cfg.occ_thr)
				nxt = ST_OCCUPIED;
			else if (cur == ST_OCCUPIED && dval > cfg.free_thr)
				nxt = ST_FREE;
			if (nxt == cur) begin
				prop_st[ch] = ST_UNKNOWN;
				prop_cnt[ch] = '0;
			end else begin
				if (prop_st[ch] == nxt) begin
					if (prop_cnt[ch] != CNT_MAX)
						prop_cnt[ch]++;
				end else begin
					prop_st[ch] = nxt;
					prop_cnt[ch] = 4'd1;
				end
				if (prop_cnt[ch] >= cfg.confirm) begin
					qual_st[ch] = nxt;
					prop_st[ch] = ST_UNKNOWN;
					prop_cnt[ch] = '0;
				end
			end
			if (qual_st[ch] != ST_UNKNOWN && qual_st[ch] != rep_st[ch]) begin
				r.changed = 1'b1;
				rep_st[ch] = qual_st[ch];
			end
			r.dval = dval;
		end
		r.state = qual_st[ch];
		r.faulty = fault_st[ch];
		return r;
	endfunction

	// drives one beat in a burst/gap pattern and returns the predicted report
	task automatic offer(input logic [SPOT_W-1:0] ch, input logic to,
			input logic [DIST_W-1:0] dval, output spot_report_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(8, 1);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		burst_left--;
		@(negedge clk);
		in_valid  <= 1'b1;
		spot      <= ch;
		timed_out <= to;
		distance  <= dval;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		r = predict_report(ch, to, dval);
	endtask

	task automatic send_beat(input logic [SPOT_W-1:0] ch, input logic to,
			input logic [DIST_W-1:0] dval);
		spot_report_t r;
		offer(ch, to, dval, r);
		pending_reports.push_back(r);
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] want;
		logic [PDATA_W-1:0] got;
		case (idx)
			REG_OCC_THR:  cfg.occ_thr   = val[DIST_W-1:0];
			REG_FREE_THR: cfg.free_thr  = val[DIST_W-1:0];
			REG_CONFIRM:  cfg.confirm   = val[CNT_W-1:0];
			REG_TIMEOUT:  cfg.tmo_limit = val[CNT_W-1:0];
			default: ;
		endcase
		case (idx)
			REG_OCC_THR:  want = PDATA_W'(cfg.occ_thr);
			REG_FREE_THR: want = PDATA_W'(cfg.free_thr);
			REG_CONFIRM:  want = PDATA_W'(cfg.confirm);
			default:      want = PDATA_W'(cfg.tmo_limit);
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_field("register readback", int'(got), int'(want));
	endtask

	function automatic logic [DIST_W-1:0] pick_distance(input int kind);
		int v;
		v = $urandom_range(65535, 0);
		case (kind)
			0: if (cfg.occ_thr != 0) v = $urandom_range(int'(cfg.occ_thr) - 1, 0);
			1: if (cfg.free_thr != 16'hFFFF) v = $urandom_range(65535, int'(cfg.free_thr) + 1);
			2: v = int'(cfg.occ_thr) + $urandom_range(3, 0) - 2;
			3: v = int'(cfg.free_thr) + $urandom_range(3, 0) - 2;
			default: ;
		endcase
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return v[DIST_W-1:0];
	endfunction

	task automatic noise_beat;
		send_beat(SPOT_W'($urandom_range(15, 0)), $urandom_range(6, 0) == 0,
			pick_distance($urandom_range(5, 0)));
	endtask

	// mostly confirmation runs and timeout runs on one channel, with noise around them
	task automatic run_random(input int n);
		int goal;
		int k;
		int side;
		int pick;
		logic [SPOT_W-1:0] ch;
		goal = beats_sent + n;
		while (beats_sent < goal) begin
			ch = SPOT_W'($urandom_range(15, 0));
			pick = $urandom_range(9, 0);
			if (pick < 5) begin
				side = $urandom_range(1, 0);
				k = $urandom_range(int'(cfg.confirm) + 2, 1);
				repeat (k) begin
					if ($urandom_range(3, 0) == 0)
						noise_beat();
					send_beat(ch, 1'b0, pick_distance(($urandom_range(4, 0) == 0) ? side + 2 : side));
				end
			end else if (pick < 7) begin
				k = $urandom_range(18, 1);
				repeat (k) send_beat(ch, 1'b1, DIST_W'($urandom_range(65535, 0)));
				if ($urandom_range(1, 0) == 1)
					send_beat(ch, 1'b0, pick_distance($urandom_range(5, 0)));
			end else begin
				repeat ($urandom_range(6, 1)) noise_beat();
			end
		end
	endtask

	// receiver: own stall pattern, plus a long hold when asked
	initial begin
		int mode;
		int mode_left;
		mode = 0;
		mode_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(3, 0);
				mode_left = $urandom_range(64, 16);
			end
			mode_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(1, 0));
				2: out_ready <= ($urandom_range(3, 0) == 0);
				default: out_ready <= ((mode_left % 8) < 3);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		spot_report_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected result on spot", int'(spot_out), -1);
			end else begin
				want = pending_reports.pop_front();
				check_field("spot_out", int'(spot_out), int'(want.spot));
				check_field("spot_state", int'(spot_state), int'(want.state));
				check_field("state_changed", int'(state_changed), int'(want.changed));
				check_field("health_event", int'(health_event), int'(want.health));
				check_field("faulty", int'(faulty), int'(want.faulty));
				check_field("distance_out", int'(distance_out), int'(want.dval));
			end
		end
	end

	initial begin
		spot_report_t r;
		spot_report_t typed_r;
		logic [DIST_W-1:0] occ_v [PHASE_N];
		logic [DIST_W-1:0] free_v [PHASE_N];
		logic [CNT_W-1:0]  conf_v [PHASE_N];
		logic [CNT_W-1:0]  tmo_v [PHASE_N];
		errors = 0;
		results_seen = 0;
		cycle_cnt = 0;
		beats_sent = 0;
		burst_left = 0;
		hold_ask = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		spot = '0;
		timed_out = 1'b0;
		distance = '0;
		cfg = '{OCC_THR_RST, FREE_THR_RST, CONFIRM_RST, TIMEOUT_RST};
		for (int i = 0; i < SPOTS_DEF; i++) begin
			qual_st[i] = ST_UNKNOWN;
			prop_st[i] = ST_UNKNOWN;
			prop_cnt[i] = '0;
			miss_cnt[i] = '0;
			fault_st[i] = 1'b0;
			rep_st[i] = ST_UNKNOWN;
		end

		// spot, timeout, distance, typed, state, changed, health, faulty
		dir_tab[0]  = '{4'd0,  1'b0, 16'd0,     1'b1, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[1]  = '{4'd15, 1'b0, 16'd65535, 1'b1, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[2]  = '{4'd0,  1'b0, 16'd0,     1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[3]  = '{4'd0,  1'b0, 16'd0,     1'b1, ST_OCCUPIED, 1'b1, HE_NONE,    1'b0};
		dir_tab[4]  = '{4'd3,  1'b1, 16'd0,     1'b1, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[5]  = '{4'd3,  1'b1, 16'd1234,  1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[6]  = '{4'd3,  1'b1, 16'd65535, 1'b1, ST_UNKNOWN,  1'b0, HE_FAULT,   1'b1};
		dir_tab[7]  = '{4'd3,  1'b1, 16'd0,     1'b1, ST_UNKNOWN,  1'b0, HE_NONE,    1'b1};
		dir_tab[8]  = '{4'd3,  1'b0, 16'd9000,  1'b1, ST_UNKNOWN,  1'b0, HE_RECOVER, 1'b0};
		dir_tab[9]  = '{4'd0,  1'b0, 16'd10000, 1'b1, ST_OCCUPIED, 1'b0, HE_NONE,    1'b0};
		dir_tab[10] = '{4'd0,  1'b0, 16'd10001, 1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[11] = '{4'd0,  1'b0, 16'd7999,  1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[12] = '{4'd0,  1'b0, 16'd10001, 1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[13] = '{4'd0,  1'b0, 16'd10001, 1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[14] = '{4'd0,  1'b0, 16'd10001, 1'b1, ST_FREE,     1'b1, HE_NONE,    1'b0};
		dir_tab[15] = '{4'd0,  1'b0, 16'd8000,  1'b1, ST_FREE,     1'b0, HE_NONE,    1'b0};
		dir_tab[16] = '{4'd0,  1'b0, 16'd7999,  1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[17] = '{4'd15, 1'b1, 16'd65535, 1'b1, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[18] = '{4'd15, 1'b0, 16'd10001, 1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[19] = '{4'd15, 1'b0, 16'd40000, 1'b1, ST_FREE,     1'b1, HE_NONE,    1'b0};
		dir_tab[20] = '{4'd9,  1'b0, 16'h5555,  1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};
		dir_tab[21] = '{4'd10, 1'b0, 16'hAAAA,  1'b0, ST_UNKNOWN,  1'b0, HE_NONE,    1'b0};

		occ_v[0] = 16'd0;     free_v[0] = 16'hFFFF; conf_v[0] = 4'd0;  tmo_v[0] = 4'd0;
		occ_v[1] = 16'hFFFF;  free_v[1] = 16'd0;    conf_v[1] = CNT_MAX; tmo_v[1] = CNT_MAX;
		occ_v[2] = 16'd3000;  free_v[2] = 16'd4000; conf_v[2] = 4'd1;  tmo_v[2] = 4'd1;
		occ_v[3] = OCC_THR_RST; free_v[3] = FREE_THR_RST; conf_v[3] = CONFIRM_RST;
		tmo_v[3] = TIMEOUT_RST;
		occ_v[4] = DIST_W'($urandom_range(30000, 0));
		free_v[4] = DIST_W'(occ_v[4] + $urandom_range(30000, 0));
		conf_v[4] = CNT_W'($urandom_range(15, 0));
		tmo_v[4] = CNT_W'($urandom_range(15, 0));
		occ_v[5] = DIST_W'($urandom_range(65535, 0));
		free_v[5] = DIST_W'($urandom_range(65535, 0));
		conf_v[5] = CNT_W'($urandom_range(15, 0));
		tmo_v[5] = CNT_W'($urandom_range(15, 0));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			offer(dir_tab[i].spot, dir_tab[i].to, dir_tab[i].dval, r);
			if (dir_tab[i].typed) begin
				typed_r.spot    = dir_tab[i].spot;
				typed_r.state   = dir_tab[i].e_state;
				typed_r.changed = dir_tab[i].e_changed;
				typed_r.health  = dir_tab[i].e_health;
				typed_r.faulty  = dir_tab[i].e_faulty;
				typed_r.dval    = dir_tab[i].to ? '0 : dir_tab[i].dval;
				pending_reports.push_back(typed_r);
			end else begin
				pending_reports.push_back(r);
			end
		end
		drain();

		for (int p = 0; p < PHASE_N; p++) begin
			set_reg(REG_OCC_THR, PDATA_W'(occ_v[p]));
			set_reg(REG_FREE_THR, PDATA_W'(free_v[p]));
			set_reg(REG_CONFIRM, PDATA_W'(conf_v[p]));
			set_reg(REG_TIMEOUT, PDATA_W'(tmo_v[p]));
			// long receiver hold while the sender keeps pushing
			if (p == 3)
				hold_ask = 1'b1;
			run_random(PHASE_BEATS);
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
